// ----- rtl/ctcg_pkg.sv -----
package ctcg_pkg;

    localparam int SCORE_W       = 16;
    localparam int MAG_W         = 15;
    localparam int SYMBOL_W      = 7;
    localparam int CLASS_COUNT_W = 8;
    localparam int STEP_COUNT_W  = 7;
    localparam int CFG_DATA_W    = 15;
    localparam int CFG_INDEX_W   = 2;

    // binary16 field masks
    localparam logic [SCORE_W-1:0] HALF_EXP_MASK  = 16'h7c00;
    localparam logic [SCORE_W-1:0] HALF_SIGN_MASK = 16'h8000;
    localparam logic [MAG_W-1:0]   HALF_INF_MAG   = 15'h7c00;

    localparam logic [CLASS_COUNT_W-1:0] CLASS_COUNT_RST = 8'd88;
    localparam logic [STEP_COUNT_W-1:0]  STEP_COUNT_RST  = 7'd35;
    localparam logic [MAG_W-1:0]         THRESHOLD_RST   = 15'd13312;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLASS_COUNT     = 2'd0,
        REG_STEP_COUNT      = 2'd1,
        REG_SCORE_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CLASS_COUNT_W-1:0] class_count;
        logic [STEP_COUNT_W-1:0]  step_count;
        logic [MAG_W-1:0]         score_threshold;
    } cfg_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                symbol_valid;
        logic                sequence_done;
    } result_t;

endpackage

// ----- rtl/ctc_greedy_decoder_top.sv -----
// Flow: each score word is held in the input register and scored there; a word that closes
//   a step loads its result word into the output register once no result word is stalled.
// Throughput: one score word per cycle, one result word per step of class_count scores,
//   clamped to 2..MAX_CLASSES; a closing word that must wait stalls the score stream.
// Reset: aresetn is synchronous, active low; it restores the register defaults and
//   restarts the sequence at once, with no clearing pass.
module ctc_greedy_decoder_top
    import ctcg_pkg::*;
#(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // score stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [15:0]            s_tdata,   // [15:0] score
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [6:0] symbol, [7] zero
    output logic [0:0]             m_tuser,   // [0] symbol_valid
    output logic                   m_tlast,   // sequence_done
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // Configuration registers
    cfg_t cfg_reg, cfg_next;
    logic restart;

    always_comb begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CLASS_COUNT: begin
                    cfg_next.class_count = cfg_wdata[CLASS_COUNT_W-1:0];
                    restart              = 1'b1;
                end
                REG_STEP_COUNT: begin
                    cfg_next.step_count = cfg_wdata[STEP_COUNT_W-1:0];
                    restart             = 1'b1;
                end
                REG_SCORE_THRESHOLD: begin
                    cfg_next.score_threshold = cfg_wdata[MAG_W-1:0];
                    restart                  = 1'b1;
                end
                default: begin
                    // index beyond the register list: drop the write
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_count     <= CLASS_COUNT_RST;
            cfg_reg.step_count      <= STEP_COUNT_RST;
            cfg_reg.score_threshold <= THRESHOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: hold one score word until the tracker takes it.
    logic               in_valid_reg, in_valid_next;
    logic [SCORE_W-1:0] in_score_reg;
    logic               end_of_step;
    logic               advance;
    logic               out_free;

    // A word that closes a step needs room in the output register; any other word
    // only updates the running best and moves on.
    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && (!end_of_step || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_score_reg <= s_tdata;
        end
    end

    // Flush, qualify and compare against the running best of the step.
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] best_score;
    logic             qualifies;

    ctcg_score_filter u_filter (
        .score      (in_score_reg),
        .threshold  (cfg_reg.score_threshold),
        .best_score (best_score),
        .mag        (mag),
        .qualifies  (qualifies)
    );

    // Class and step positions, running best, previous step's class.
    result_t result;

    ctcg_track #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS)
    ) u_track (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .restart             (restart),
        .restart_class_count (cfg_next.class_count),
        .step_en             (advance),
        .qualifies           (qualifies),
        .mag                 (mag),
        .best_score          (best_score),
        .end_of_step         (end_of_step),
        .result              (result)
    );

    // Output register: load the step result on the word that closes a step.
    ctcg_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && end_of_step),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/ctcg_score_filter.sv -----
module ctcg_score_filter
    import ctcg_pkg::*;
(
    input  logic [SCORE_W-1:0] score,
    input  logic [MAG_W-1:0]   threshold,
    input  logic [MAG_W-1:0]   best_score,
    output logic [MAG_W-1:0]   mag,
    output logic               qualifies
);

    logic exp_zero;
    logic negative;

    always_comb begin
        exp_zero  = (score & HALF_EXP_MASK) == '0;
        negative  = (score & HALF_SIGN_MASK) != '0;
        // flush zero-exponent scores to zero
        mag       = exp_zero ? '0 : score[MAG_W-1:0];
        // NaN sits above the infinity pattern
        qualifies = !exp_zero && !negative && (mag <= HALF_INF_MAG)
                    && (mag > threshold) && (mag > best_score);
    end

endmodule

// ----- rtl/ctcg_track.sv -----
module ctcg_track
    import ctcg_pkg::*;
#(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     restart,
    input  logic [CLASS_COUNT_W-1:0] restart_class_count,
    input  logic                     step_en,
    input  logic                     qualifies,
    input  logic [MAG_W-1:0]         mag,
    output logic [MAG_W-1:0]         best_score,
    output logic                     end_of_step,
    output result_t                  result
);

    localparam int CW   = $clog2(MAX_CLASSES);
    localparam int CCW  = $clog2(MAX_CLASSES + 1);
    localparam int CXW  = (CCW > CLASS_COUNT_W) ? CCW : CLASS_COUNT_W;
    localparam int SW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int SCW  = $clog2(MAX_STEPS + 1);
    localparam int SXW  = (SCW > STEP_COUNT_W) ? SCW : STEP_COUNT_W;

    function automatic logic [CW-1:0] blank_of(input logic [CLASS_COUNT_W-1:0] cc);
        logic [CXW-1:0] c;
        c = CXW'(cc);
        if (c < CXW'(2)) begin
            c = CXW'(2);
        end else if (c > CXW'(MAX_CLASSES)) begin
            c = CXW'(MAX_CLASSES);
        end
        c = c - CXW'(1);
        return c[CW-1:0];
    endfunction

    function automatic logic [SW-1:0] last_step_of(input logic [STEP_COUNT_W-1:0] sc);
        logic [SXW-1:0] s;
        s = SXW'(sc);
        if (s < SXW'(1)) begin
            s = SXW'(1);
        end else if (s > SXW'(MAX_STEPS)) begin
            s = SXW'(MAX_STEPS);
        end
        s = s - SXW'(1);
        return s[SW-1:0];
    endfunction

    logic [CW-1:0]    class_pos_reg,  class_pos_next;
    logic [SW-1:0]    step_pos_reg,   step_pos_next;
    logic [MAG_W-1:0] best_score_reg, best_score_next;
    logic [CW-1:0]    best_class_reg, best_class_next;
    logic [CW-1:0]    prev_class_reg, prev_class_next;

    logic [CW-1:0]          blank;
    logic [CW-1:0]          cur_best;
    logic                   last_step;
    logic                   emit;
    logic [CW+SYMBOL_W-1:0] symbol_ext;

    always_comb begin
        blank       = blank_of(cfg.class_count);
        cur_best    = qualifies ? class_pos_reg : best_class_reg;
        end_of_step = class_pos_reg == blank;
        last_step   = step_pos_reg == last_step_of(cfg.step_count);
        emit        = (cur_best != blank) && (cur_best != prev_class_reg);
        symbol_ext  = {{SYMBOL_W{1'b0}}, cur_best};

        result.symbol        = emit ? symbol_ext[SYMBOL_W-1:0] : '0;
        result.symbol_valid  = emit;
        result.sequence_done = last_step;

        class_pos_next  = class_pos_reg;
        step_pos_next   = step_pos_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        prev_class_next = prev_class_reg;

        if (restart) begin
            class_pos_next  = '0;
            step_pos_next   = '0;
            best_score_next = '0;
            best_class_next = blank_of(restart_class_count);
            prev_class_next = blank_of(restart_class_count);
        end else if (step_en) begin
            if (!end_of_step) begin
                class_pos_next = class_pos_reg + CW'(1);
                if (qualifies) begin
                    best_score_next = mag;
                    best_class_next = class_pos_reg;
                end
            end else begin
                class_pos_next  = '0;
                best_score_next = '0;
                best_class_next = blank;
                if (last_step) begin
                    step_pos_next   = '0;
                    prev_class_next = blank;
                end else begin
                    step_pos_next   = step_pos_reg + SW'(1);
                    prev_class_next = cur_best;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_pos_reg  <= '0;
            step_pos_reg   <= '0;
            best_score_reg <= '0;
            best_class_reg <= blank_of(CLASS_COUNT_RST);
            prev_class_reg <= blank_of(CLASS_COUNT_RST);
        end else begin
            class_pos_reg  <= class_pos_next;
            step_pos_reg   <= step_pos_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            prev_class_reg <= prev_class_next;
        end
    end

    assign best_score = best_score_reg;

endmodule

// ----- rtl/ctcg_out_reg.sv -----
module ctcg_out_reg
    import ctcg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     result,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [7:0]  m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg.symbol};
    assign m_tuser  = data_reg.symbol_valid;
    assign m_tlast  = data_reg.sequence_done;

endmodule

// ----- rtl/ctcg_checker.sv -----
module ctcg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // no symbol means a zero symbol field
    a_symbol_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("symbol nonzero without symbol_valid");

    // reset drops any pending result word
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a free output register never stalls the score stream
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !m_tvalid && $past(!m_tvalid) && $past(aresetn) |-> s_tready)
        else $error("score stream stalled with an empty result side");

endmodule

bind ctc_greedy_decoder_top ctcg_checker u_ctcg_checker (.*);

// ----- test/ctc_greedy_decoder_top_test.sv -----
`timescale 1ns / 100ps

module ctc_greedy_decoder_top_test;
    import ctcg_pkg::*;

    localparam int MAX_CLASSES = 128;
    localparam int MAX_STEPS   = 64;
    // one index past the register list; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    // cycles to let pass once the last result word is in (input to output register)
    localparam int DRAIN_CYCLES = 4;
    localparam int SQUEEZE_CYCLES = 200;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;   // [15:0] score
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;          // [6:0] symbol, [7] zero
    logic [0:0]             m_tuser;          // [0] symbol_valid
    logic                   m_tlast;          // sequence_done
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    ctc_greedy_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Decoder mirror: registers and per-step state, advanced one score
    // word at a time as the DUT accepts them.
    // ------------------------------------------------------------------
    logic [CLASS_COUNT_W-1:0] cfg_classes;
    logic [STEP_COUNT_W-1:0]  cfg_steps;
    logic [MAG_W-1:0]         cfg_thresh;
    int                       class_pos;
    int                       step_pos;
    logic [MAG_W-1:0]         best_mag;
    logic [SYMBOL_W-1:0]      best_cls;
    logic [SYMBOL_W-1:0]      prev_cls;

    logic [15:0] scores_to_send[$];   // score words not yet accepted
    result_t     pending_symbols[$];  // result words still owed by the DUT
    int unsigned errors = 0;

    // idling and back-pressure controls; set at the falling edge, gaps and squeeze request consumed at the rising edge
    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;
    bit squeeze_request = 1'b0;
    int s_gap;
    int m_gap;
    logic [15:0] last_pick = '0;

    function automatic int live_classes();
        if (cfg_classes < 2) return 2;
        if (cfg_classes > MAX_CLASSES) return MAX_CLASSES;
        return int'(cfg_classes);
    endfunction

    function automatic int live_steps();
        if (cfg_steps < 1) return 1;
        if (cfg_steps > MAX_STEPS) return MAX_STEPS;
        return int'(cfg_steps);
    endfunction

    // Any accepted register write starts a fresh sequence.
    task automatic restart_sequence();
        class_pos = 0;
        step_pos  = 0;
        best_mag  = '0;
        best_cls  = SYMBOL_W'(live_classes() - 1);
        prev_cls  = SYMBOL_W'(live_classes() - 1);
    endtask

    task automatic mirror_reset();
        cfg_classes = CLASS_COUNT_RST;
        cfg_steps   = STEP_COUNT_RST;
        cfg_thresh  = THRESHOLD_RST;
        restart_sequence();
    endtask

    task automatic mirror_config(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        bit hit;
        hit = 1'b1;
        case (idx)
            REG_CLASS_COUNT:     cfg_classes = val[CLASS_COUNT_W-1:0];
            REG_STEP_COUNT:      cfg_steps   = val[STEP_COUNT_W-1:0];
            REG_SCORE_THRESHOLD: cfg_thresh  = val[MAG_W-1:0];
            default:             hit = 1'b0;
        endcase
        if (hit) restart_sequence();
    endtask

    // Fold one score into the running best; at the end of a step queue
    // the result word the DUT owes.
    task automatic decode_score(input logic [15:0] score_in);
        logic [15:0]         raw;
        logic [MAG_W-1:0]    mag;
        logic [SYMBOL_W-1:0] blank;
        int                  classes;
        result_t             res;
        classes = live_classes();
        blank   = SYMBOL_W'(classes - 1);
        raw     = score_in;
        // flush subnormals and zeros
        if ((raw & HALF_EXP_MASK) == '0) raw = '0;
        mag = raw[MAG_W-1:0];
        // sign set or NaN never qualifies; ties keep the earlier class
        if (!raw[15] && mag <= HALF_INF_MAG && mag > cfg_thresh && mag > best_mag) begin
            best_mag = mag;
            best_cls = SYMBOL_W'(class_pos);
        end
        if (class_pos + 1 < classes) begin
            class_pos++;
        end else begin
            res.symbol_valid  = (best_cls != blank) && (best_cls != prev_cls);
            res.symbol        = res.symbol_valid ? best_cls : '0;
            res.sequence_done = (step_pos + 1 >= live_steps());
            pending_symbols.push_back(res);
            prev_cls  = best_cls;
            class_pos = 0;
            best_mag  = '0;
            best_cls  = blank;
            if (res.sequence_done) begin
                step_pos = 0;
                prev_cls = blank;
            end else begin
                step_pos++;
            end
        end
    endtask

    // Mix of raw noise, special encodings, repeats (ties) and values that
    // straddle the threshold, so strict-maximum decisions get exercised.
    function automatic logic [15:0] next_score();
        logic [15:0] v;
        int          t;
        case ($urandom_range(0, 9))
            0: v = 16'($urandom_range(0, 65535));
            1: begin
                case ($urandom_range(0, 6))
                    0: v = 16'h7c00;                                  // +inf
                    1: v = 16'hfc00;                                  // -inf
                    2: v = 16'h7c00 | 16'($urandom_range(1, 1023));   // NaN
                    3: v = 16'h8000;                                  // -0
                    4: v = 16'($urandom_range(1, 1023));              // subnormal
                    5: v = 16'h0000;
                    default: v = 16'h7bff;                            // max finite
                endcase
            end
            2: v = last_pick;
            3, 4, 5: begin
                t = int'(cfg_thresh) + int'($urandom_range(0, 6)) - 3;
                if (t < 0) t = 0;
                if (t > 32767) t = 32767;
                v = {($urandom_range(0, 7) == 0), 15'(t)};
            end
            default: v = {1'b0, 5'($urandom_range(1, 30)), 10'($urandom_range(0, 1023))};
        endcase
        last_pick = v;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the oldest pending score word, hold it while stalled,
    // and drop valid in random bursts when idling is on.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : score_driver
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
            mirror_reset();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_score(s_tdata);
                void'(scores_to_send.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;                      // hold the word until taken
            end else if (s_gap > 0) begin
                s_gap--;
                offer = 1'b0;
            end else if (scores_to_send.size() != 0 && s_idle_on &&
                         $urandom_range(0, 7) == 0) begin
                s_gap = $urandom_range(1, 18) - 1;
                offer = 1'b0;
            end else begin
                offer = (scores_to_send.size() != 0);
            end
            s_tvalid <= offer;
            if (offer) s_tdata <= scores_to_send[0];
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result word against the oldest owed
    // one; stall ready in random bursts, plus one long squeeze on request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_symbols.size() == 0) begin
                    $display("%0t: unexpected result word: tdata=%h tuser=%b tlast=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = pending_symbols.pop_front();
                    if (m_tdata !== {1'b0, want.symbol}) begin
                        $display("%0t: symbol mismatch: expected %h, actual %h",
                                 $time, {1'b0, want.symbol}, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.symbol_valid) begin
                        $display("%0t: symbol_valid mismatch: expected %b, actual %b",
                                 $time, want.symbol_valid, m_tuser[0]);
                        errors++;
                    end
                    if (m_tlast !== want.sequence_done) begin
                        $display("%0t: sequence_done mismatch: expected %b, actual %b",
                                 $time, want.sequence_done, m_tlast);
                        errors++;
                    end
                end
            end
            if (squeeze_request) begin
                // long hold-off: the DUT must fill up and stall the score side
                squeeze_request = 1'b0;
                m_gap = SQUEEZE_CYCLES;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else if (m_idle_on && $urandom_range(0, 7) == 0) begin
                m_gap = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Write one register; the mirror follows once the write has landed.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mirror_config(idx, val);
    endtask

    // Queue a batch of random score words and set the idling for it.
    task automatic push_scores(input int count, input bit idle, input bit squeeze);
        @(negedge aclk);
        s_idle_on = idle;
        m_idle_on = idle;
        if (squeeze) squeeze_request = 1'b1;
        for (int i = 0; i < count; i++) scores_to_send.push_back(next_score());
    endtask

    // Wait until every word is taken and every result is in, then let the
    // pipeline settle so a partial step cannot overlap a register write.
    task automatic wait_drain();
        do @(negedge aclk);
        while (scores_to_send.size() != 0 || s_tvalid || pending_symbols.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [15:0] directed[$];
        int          n_cls;
        int          n_steps;
        logic [MAG_W-1:0] thr;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: one full step and part of the next, then a write
        // to an unused index, which must not restart the step.
        push_scores(130, 1'b1, 1'b0);
        wait_drain();
        write_reg(REG_UNUSED, 15'h7fff);
        push_scores(46, 1'b1, 1'b0);
        wait_drain();

        // Directed: three classes (class 2 is blank), two steps per sequence.
        write_reg(REG_CLASS_COUNT, 15'd3);
        write_reg(REG_STEP_COUNT, 15'd2);
        write_reg(REG_SCORE_THRESHOLD, 15'h3400);
        directed = '{
            16'h3c00, 16'h3c00, 16'h0000,   // tie keeps class 0
            16'h0000, 16'h03ff, 16'h7c00,   // subnormal flushed, inf lands on blank
            16'h7e00, 16'hfc00, 16'h8000,   // NaN, -inf, -0: nothing qualifies
            16'h3400, 16'h7bff, 16'h3401,   // equal to threshold fails, class 1
            16'h3800, 16'h3c00, 16'h0000,   // rising scores pick class 1
            16'h0000, 16'h4000, 16'h7fff,   // class 1 repeats, no symbol
            16'h7c00, 16'h7c00, 16'h8001,   // inf qualifies, class 0
            16'h3c00, 16'h3c00, 16'h3c00    // class 0 repeats
        };
        @(negedge aclk);
        foreach (directed[i]) scores_to_send.push_back(directed[i]);
        wait_drain();
        // threshold at infinity: blank every time
        write_reg(REG_SCORE_THRESHOLD, HALF_INF_MAG);
        @(negedge aclk);
        scores_to_send.push_back(16'h7c00);
        scores_to_send.push_back(16'h7bff);
        scores_to_send.push_back(16'h7fff);
        wait_drain();

        // Class count above the maximum acts as the maximum.
        write_reg(REG_CLASS_COUNT, 15'd255);
        write_reg(REG_STEP_COUNT, 15'd2);
        write_reg(REG_SCORE_THRESHOLD, 15'h3000);
        push_scores(256, 1'b1, 1'b0);
        wait_drain();

        // Zero counts act as two classes and one step; hold the result side
        // off for a long stretch so the score side stalls.
        write_reg(REG_CLASS_COUNT, 15'd0);
        write_reg(REG_STEP_COUNT, 15'd0);
        push_scores(20, 1'b1, 1'b1);
        wait_drain();

        // One class acts as two; step count beyond the maximum acts as 64.
        write_reg(REG_CLASS_COUNT, 15'd1);
        write_reg(REG_STEP_COUNT, 15'd127);
        write_reg(REG_SCORE_THRESHOLD, 15'd0);
        push_scores(130, 1'b0, 1'b0);
        wait_drain();

        // Random settings, mostly small class counts so results come often.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 9))
                0: n_cls = 0;
                1: n_cls = 1;
                2: n_cls = $urandom_range(9, 40);
                default: n_cls = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 7))
                0: n_steps = 0;
                1: n_steps = $urandom_range(64, 127);
                default: n_steps = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 7))
                0: thr = '0;
                1: thr = HALF_INF_MAG;
                2: thr = 15'h7fff;
                3: thr = THRESHOLD_RST;
                default: thr = 15'($urandom_range(0, 32'h7bff));
            endcase
            // upper data bits beyond a register's width must be dropped
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_CLASS_COUNT, {7'($urandom), 8'(n_cls)});
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_STEP_COUNT, {8'($urandom), 7'(n_steps)});
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_SCORE_THRESHOLD, thr);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 15'($urandom));
            push_scores($urandom_range(40, 70), ($urandom_range(0, 3) != 0), (ph == 3));
            wait_drain();
        end

        // Closing stretch at full rate, no idling on either side.
        write_reg(REG_CLASS_COUNT, 15'd3);
        write_reg(REG_STEP_COUNT, 15'd4);
        write_reg(REG_SCORE_THRESHOLD, THRESHOLD_RST);
        push_scores(60, 1'b0, 1'b0);
        wait_drain();

        if (errors == 0 && pending_symbols.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- ctc_greedy_decoder_top.f -----
rtl/ctcg_pkg.sv
rtl/ctcg_score_filter.sv
rtl/ctcg_track.sv
rtl/ctcg_out_reg.sv
rtl/ctc_greedy_decoder_top.sv
rtl/ctcg_checker.sv
test/ctc_greedy_decoder_top_test.sv
